[rtl/atrc_pkg.sv]
// Shared types, codes and constants of the AT response line classifier.
package atrc_pkg;

  // Parameter defaults
  localparam int LINE_CAPACITY_DEF = 64;
  localparam int EXPECT_MAX_DEF    = 8;

  // Bytes of each line held for pattern matching
  localparam int HEAD_BYTES = 12;

  // Register map (index = paddr[4:3])
  localparam int          CFG_ADDR_W         = 5;
  localparam logic [1:0]  REG_EXPECT_PATTERN = 2'd0;
  localparam logic [1:0]  REG_EXPECT_LENGTH  = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT_TICKS  = 2'd2;
  localparam logic [31:0] TIMEOUT_RESET      = 32'd1000;

  // Request actions
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DROP = 8'hFF;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_R    = 8'h52;

  // Unsolicited patterns, right-aligned string literals
  localparam logic [95:0] PAT_CMTI       = "+CMTI:";
  localparam logic [95:0] PAT_CREG       = "+CREG:";
  localparam logic [95:0] PAT_HTTPACTION = "+HTTPACTION:";
  localparam logic [95:0] PAT_HTTPREAD   = "+HTTPREAD:";
  localparam logic [95:0] PAT_RING       = "RING";

  typedef enum logic [3:0] {
    KIND_PRIMARY      = 4'd0,
    KIND_OK           = 4'd1,
    KIND_ERROR        = 4'd2,
    KIND_INTERMEDIATE = 4'd3,
    KIND_TIMEOUT      = 4'd4,
    KIND_SMS          = 4'd5,
    KIND_REGISTRATION = 4'd6,
    KIND_HTTP_ACTION  = 4'd7,
    KIND_HTTP_READ    = 4'd8,
    KIND_RING         = 4'd9,
    KIND_ACCEPTED     = 4'd10,
    KIND_REJECTED     = 4'd11
  } kind_t;

  typedef struct packed {
    logic [63:0] expect_pattern;
    logic [3:0]  expect_length;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [5:0] line_length;
  } result_t;

  typedef struct packed {
    logic busy;
  } status_t;

endpackage

[rtl/atrc_cfg.sv]
// APB register file for the expected prefix and the command timeout.
module atrc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [atrc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [63:0]                        pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready,
  output atrc_pkg::cfg_t                     cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:3];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expect_pattern <= '0;
      cfg.expect_length  <= '0;
      cfg.timeout_ticks  <= atrc_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        atrc_pkg::REG_EXPECT_PATTERN: cfg.expect_pattern <= pwdata;
        atrc_pkg::REG_EXPECT_LENGTH:  cfg.expect_length  <= pwdata[3:0];
        atrc_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      atrc_pkg::REG_EXPECT_PATTERN: prdata = cfg.expect_pattern;
      atrc_pkg::REG_EXPECT_LENGTH:  prdata = {60'd0, cfg.expect_length};
      atrc_pkg::REG_TIMEOUT_TICKS:  prdata = {32'd0, cfg.timeout_ticks};
      default:                      prdata = '0;
    endcase
  end

endmodule

[rtl/atrc_line.sv]
// Line state, command state and line classification for one request per cycle while step is high.
module atrc_line #(
  parameter int LINE_CAPACITY = atrc_pkg::LINE_CAPACITY_DEF,
  parameter int EXPECT_MAX    = atrc_pkg::EXPECT_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           action,
  input  logic [7:0]           byte_value,
  input  atrc_pkg::cfg_t       cfg,
  output atrc_pkg::result_t    res,
  output atrc_pkg::status_t    status
);

  localparam int KW = $clog2(LINE_CAPACITY);
  localparam int PW = 8 * EXPECT_MAX;

  // Line state
  logic [KW-1:0] kept_count, kept_count_next;
  logic          first_is_break, first_is_break_next;
  logic          prev_was_o, prev_was_o_next;
  logic          ok_seen, ok_seen_next;
  logic [2:0]    error_progress, error_progress_next;
  logic          error_seen, error_seen_next;
  logic [7:0]    line_head [atrc_pkg::HEAD_BYTES];
  logic [7:0]    line_head_next [atrc_pkg::HEAD_BYTES];

  // Command state
  logic          busy, busy_next;
  logic [31:0]   elapsed, elapsed_next;
  logic [PW-1:0] cmd_pattern;
  logic [3:0]    cmd_length;
  logic [31:0]   cmd_timeout;
  logic          cmd_load;

  // Working values after the current byte is taken in
  logic [KW-1:0] kept_u;
  logic [8:0]    kept_ext, kept_u_ext;
  logic          keep, prefix_ok;
  logic [31:0]   elapsed_inc;

  function automatic logic head_starts(input logic [95:0] pat, input int unsigned n,
                                       input logic [7:0] hd [atrc_pkg::HEAD_BYTES],
                                       input logic [8:0] cnt);
    logic ok;
    ok = (cnt >= 9'(n));
    for (int unsigned i = 0; i < atrc_pkg::HEAD_BYTES; i++) begin
      if (i < n && hd[i] != pat[8*(n-1-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  assign status.busy = busy;
  assign kept_ext    = 9'(kept_count);
  assign keep        = (byte_value != atrc_pkg::CH_DROP) &&
                       (kept_count < KW'(LINE_CAPACITY - 1));
  assign elapsed_inc = elapsed + 32'd1;

  always_comb begin
    kept_count_next     = kept_count;
    first_is_break_next = first_is_break;
    prev_was_o_next     = prev_was_o;
    ok_seen_next        = ok_seen;
    error_progress_next = error_progress;
    error_seen_next     = error_seen;
    line_head_next      = line_head;
    busy_next           = busy;
    elapsed_next        = elapsed;
    cmd_load            = 1'b0;
    res                 = '{valid: 1'b0, kind: atrc_pkg::KIND_PRIMARY, line_length: 6'd0};
    kept_u              = kept_count;
    prefix_ok           = 1'b0;

    // Take the byte into the line and the word trackers
    if (keep) begin
      if (kept_count == '0 && (byte_value == atrc_pkg::CH_CR || byte_value == atrc_pkg::CH_LF))
        first_is_break_next = 1'b1;
      if (kept_ext < 9'(atrc_pkg::HEAD_BYTES))
        line_head_next[kept_ext[3:0]] = byte_value;
      kept_u = kept_count + KW'(1);
      if (prev_was_o && byte_value == atrc_pkg::CH_K) ok_seen_next = 1'b1;
      prev_was_o_next = (byte_value == atrc_pkg::CH_O);
      priority if (byte_value == atrc_pkg::CH_E)
        error_progress_next = 3'd1;
      else if (byte_value == atrc_pkg::CH_R &&
               (error_progress == 3'd1 || error_progress == 3'd2))
        error_progress_next = error_progress + 3'd1;
      else if (byte_value == atrc_pkg::CH_O && error_progress == 3'd3)
        error_progress_next = 3'd4;
      else if (byte_value == atrc_pkg::CH_R && error_progress == 3'd4) begin
        error_seen_next     = 1'b1;
        error_progress_next = 3'd0;
      end else
        error_progress_next = 3'd0;
    end
    kept_u_ext = 9'(kept_u);

    // Compare the held line against the sampled prefix
    if (cmd_length != 4'd0 && kept_u_ext >= 9'(cmd_length)) begin
      prefix_ok = 1'b1;
      for (int i = 0; i < EXPECT_MAX; i++) begin
        if (4'(i) < cmd_length && line_head_next[i] != cmd_pattern[8*i +: 8])
          prefix_ok = 1'b0;
      end
    end

    unique case (action)
      atrc_pkg::ACT_BYTE: begin
        kept_count_next = kept_u;
        if (byte_value == atrc_pkg::CH_LF) begin
          res.line_length = kept_u_ext[5:0];
          if (busy) begin
            // Classify a response to the running command
            if (kept_u != '0 && !first_is_break_next) begin
              res.valid = 1'b1;
              priority if (prefix_ok) res.kind = atrc_pkg::KIND_PRIMARY;
              else if (ok_seen_next) begin
                res.kind  = atrc_pkg::KIND_OK;
                busy_next = 1'b0;
              end else if (error_seen_next) begin
                res.kind  = atrc_pkg::KIND_ERROR;
                busy_next = 1'b0;
              end else res.kind = atrc_pkg::KIND_INTERMEDIATE;
            end
          end else begin
            // Match unsolicited result patterns
            res.valid = 1'b1;
            priority if (head_starts(atrc_pkg::PAT_CMTI, 6, line_head_next, kept_u_ext))
              res.kind = atrc_pkg::KIND_SMS;
            else if (head_starts(atrc_pkg::PAT_CREG, 6, line_head_next, kept_u_ext))
              res.kind = atrc_pkg::KIND_REGISTRATION;
            else if (head_starts(atrc_pkg::PAT_HTTPACTION, 12, line_head_next, kept_u_ext))
              res.kind = atrc_pkg::KIND_HTTP_ACTION;
            else if (head_starts(atrc_pkg::PAT_HTTPREAD, 10, line_head_next, kept_u_ext))
              res.kind = atrc_pkg::KIND_HTTP_READ;
            else if (head_starts(atrc_pkg::PAT_RING, 4, line_head_next, kept_u_ext) &&
                     (kept_u_ext == 9'd4 ||
                      (kept_u_ext == 9'd5 && line_head_next[4] == atrc_pkg::CH_LF) ||
                      (kept_u_ext == 9'd6 && line_head_next[4] == atrc_pkg::CH_CR &&
                       line_head_next[5] == atrc_pkg::CH_LF)))
              res.kind = atrc_pkg::KIND_RING;
            else
              res.valid = 1'b0;
          end
          // Clear the line after a newline
          kept_count_next     = '0;
          first_is_break_next = 1'b0;
          prev_was_o_next     = 1'b0;
          ok_seen_next        = 1'b0;
          error_progress_next = 3'd0;
          error_seen_next     = 1'b0;
          for (int i = 0; i < atrc_pkg::HEAD_BYTES; i++) line_head_next[i] = 8'd0;
        end else begin
          first_is_break_next = first_is_break_next;
        end
      end
      atrc_pkg::ACT_TICK: begin
        // Line trackers hold; only the timeout counter and the busy flag move
        kept_count_next     = kept_count;
        first_is_break_next = first_is_break;
        prev_was_o_next     = prev_was_o;
        ok_seen_next        = ok_seen;
        error_progress_next = error_progress;
        error_seen_next     = error_seen;
        line_head_next      = line_head;
        if (busy) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= cmd_timeout) begin
            busy_next = 1'b0;
            res.valid = 1'b1;
            res.kind  = atrc_pkg::KIND_TIMEOUT;
          end
        end
      end
      atrc_pkg::ACT_START: begin
        kept_count_next     = kept_count;
        first_is_break_next = first_is_break;
        prev_was_o_next     = prev_was_o;
        ok_seen_next        = ok_seen;
        error_progress_next = error_progress;
        error_seen_next     = error_seen;
        line_head_next      = line_head;
        res.valid           = 1'b1;
        if (busy) begin
          res.kind = atrc_pkg::KIND_REJECTED;
        end else begin
          res.kind     = atrc_pkg::KIND_ACCEPTED;
          cmd_load     = 1'b1;
          elapsed_next = 32'd0;
          busy_next    = 1'b1;
        end
      end
      default: begin
        kept_count_next     = kept_count;
        first_is_break_next = first_is_break;
        prev_was_o_next     = prev_was_o;
        ok_seen_next        = ok_seen;
        error_progress_next = error_progress;
        error_seen_next     = error_seen;
        line_head_next      = line_head;
      end
    endcase

    if (!step) res.valid = 1'b0;
  end

  // Advance state on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count     <= '0;
      first_is_break <= 1'b0;
      prev_was_o     <= 1'b0;
      ok_seen        <= 1'b0;
      error_progress <= 3'd0;
      error_seen     <= 1'b0;
      busy           <= 1'b0;
      elapsed        <= 32'd0;
    end else if (step) begin
      kept_count     <= kept_count_next;
      first_is_break <= first_is_break_next;
      prev_was_o     <= prev_was_o_next;
      ok_seen        <= ok_seen_next;
      error_progress <= error_progress_next;
      error_seen     <= error_seen_next;
      busy           <= busy_next;
      elapsed        <= elapsed_next;
    end
  end

  // Head bytes and the sampled command settings
  always_ff @(posedge clk) begin
    if (step) line_head <= line_head_next;
    if (rst) begin
      cmd_pattern <= '0;
      cmd_length  <= 4'd0;
      cmd_timeout <= atrc_pkg::TIMEOUT_RESET;
    end else if (step && cmd_load) begin
      cmd_pattern <= cfg.expect_pattern[PW-1:0];
      cmd_length  <= (cfg.expect_length > 4'(EXPECT_MAX)) ? 4'(EXPECT_MAX)
                                                          : cfg.expect_length;
      cmd_timeout <= cfg.timeout_ticks;
    end
  end

endmodule

[rtl/at_response_line_classifier_core.sv]
// Top level of the AT response line classifier: input register, classifier, result register.
//
//  channel   | dir | handshake                | payload
//  s_*       | in  | s_tvalid / s_tready      | s_tuser[1:0] action, s_tdata[7:0] byte_value
//  m_*       | out | m_tvalid / m_tready      | m_tuser[3:0] kind, m_tdata[5:0] line_length
//  APB       | in  | psel & penable & pwrite  | paddr 8*index, pwdata / prdata 64 bits
//
// One request per cycle unless m_* back-pressures; a request passes the input register,
// then the result register, before its result is on m_*. The line and command state update in
// the single pass between those two registers. Reset is synchronous and clears
// all control state; timeout_ticks returns to 1000. When m_tvalid is high and m_tready
// is low the result register holds and one more request waits in the input register.
module at_response_line_classifier_core #(
  parameter int LINE_CAPACITY = atrc_pkg::LINE_CAPACITY_DEF,
  parameter int EXPECT_MAX    = atrc_pkg::EXPECT_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // byte_value[7:0]
  input  logic [1:0]                      s_tuser,   // action[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // line_length[5:0], zeros
  output logic [3:0]                      m_tuser,   // kind[3:0]
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [atrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);

  atrc_pkg::cfg_t    cfg;
  atrc_pkg::result_t res;
  atrc_pkg::status_t status;

  logic       req_valid;
  logic [1:0] req_action;
  logic [7:0] req_byte;
  logic       advance;

  atrc_cfg u_cfg (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  atrc_line #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .EXPECT_MAX   (EXPECT_MAX)
  ) u_line (
    .clk(clk), .rst(rst), .step(advance),
    .action(req_action), .byte_value(req_byte),
    .cfg(cfg), .res(res), .status(status)
  );

  // Process the held request when the result register is free or draining
  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= s_tuser;
      req_byte   <= s_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {2'd0, res.line_length};
      m_tuser <= res.kind;
    end
  end

  // Checks
  a_ready_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> req_valid)
    else $error("input stalled with an empty input register");

  a_no_length_on_cmd_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == atrc_pkg::KIND_TIMEOUT ||
                 m_tuser == atrc_pkg::KIND_ACCEPTED ||
                 m_tuser == atrc_pkg::KIND_REJECTED) |-> m_tdata[5:0] == 6'd0)
    else $error("command result carries a line length");

  a_busy_rises_on_start: assert property (@(posedge clk) disable iff (rst)
    $rose(status.busy) |-> $past(advance) && $past(req_action) == atrc_pkg::ACT_START &&
                           m_tvalid && m_tuser == atrc_pkg::KIND_ACCEPTED)
    else $error("command started without an accepted result");

endmodule
